>>> rtl/core/icdf_pkg.sv
package icdf_pkg;

   localparam int POS_W      = 32;
   localparam int SCALE_W    = 24;
   localparam int SCALE_FRAC = 16;
   localparam int SPROD_W    = POS_W + SCALE_W;
   localparam int MAG_W      = SPROD_W - SCALE_FRAC;
   localparam int SUM_W      = MAG_W + 2;
   localparam int CNT_W      = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_VALID    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMMETRIC_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_OFFSET    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STD_SCALE      = 3'd4;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_READY = 2'd1;
   localparam logic [1:0] STATUS_BEYOND    = 2'd2;
   localparam logic [1:0] STATUS_SATURATED = 2'd3;

   localparam logic [POS_W-1:0] NEG_ONE_Q16 = 32'hFFFF_0000;
   localparam logic [POS_W-1:0] SAT_MAX     = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] SAT_MIN     = 32'h8000_0000;

   localparam logic [CNT_W-1:0]   COUNT_RESET = 6'd1;
   localparam logic [SCALE_W-1:0] STD_RESET   = 24'd65536;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CUM_RD,
      S_CUM_CHK,
      S_POS_LO,
      S_POS_HI,
      S_DIFF,
      S_MUL,
      S_DIV,
      S_INTERP,
      S_SCALE,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      FIN_NOT_READY,
      FIN_MISS,
      FIN_GAMMA,
      FIN_SYM
   } fin_sel_type;

   typedef struct packed {
      logic        start;
      logic        cum_step;
      logic        pos_hi;
      logic        x0_load;
      logic        dx_load;
      logic        pos_direct;
      logic        mul;
      logic        div_step;
      logic        pos_interp;
      logic        scale;
      logic        fin_load;
      fin_sel_type fin_sel;
   } icdf_cmd_type;

   typedef struct packed {
      logic hit;
      logic k_zero;
      logic k_last;
      logic direct;
      logic div_done;
   } icdf_status_type;

endpackage

>>> rtl/core/icdf_ram.sv
module icdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/icdf_datapath.sv
module icdf_datapath import icdf_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PROB_BITS     = 16
) (
   input  logic                             clock,
   input  logic                             load_we,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] load_idx,
   input  logic [POS_W-1:0]                 load_position,
   input  logic [PROB_BITS:0]               load_cum_prob,
   input  logic [PROB_BITS-1:0]             uniform,
   input  logic                             symmetric_mode,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] count_limit,
   input  logic [POS_W-1:0]                 mean_offset,
   input  logic [SCALE_W-1:0]               std_scale,
   input  icdf_cmd_type                     cmd,
   output icdf_status_type                  status,
   output logic [POS_W-1:0]                 rsp_value,
   output logic [1:0]                       rsp_status
);

   localparam int AW  = $clog2(TABLE_ENTRIES);
   localparam int PW  = PROB_BITS + 1;
   localparam int DW  = POS_W + PROB_BITS;
   localparam int DCW = $clog2(DW);
   localparam logic [PROB_BITS-1:0] HALF = PROB_BITS'(1) << (PROB_BITS - 1);

   logic [PW-1:0]    cum_rdata;
   logic [POS_W-1:0] pos_rdata;
   logic [AW-1:0]    pos_raddr;

   logic [AW-1:0]        k_ff, k_in;
   logic [PROB_BITS-1:0] v_ff, v_in;
   logic                 neg_ff, neg_in;
   logic [PW-1:0]        y0_ff, y0_in;
   logic [POS_W-1:0]     x0_ff, x0_in;
   logic [POS_W-1:0]     dx_mag_ff, dx_mag_in;
   logic                 dx_neg_ff, dx_neg_in;
   logic [PW-1:0]        den_ff, den_in;
   logic [DW-1:0]        dq_ff, dq_in;
   logic [PW:0]          rem_ff, rem_in;
   logic [DCW-1:0]       div_cnt_ff, div_cnt_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [SPROD_W-1:0]   sprod_ff, sprod_in;
   logic [POS_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic [PW-1:0]        v_ext;
   logic [PW-1:0]        num_full;
   logic [PW:0]          shifted;
   logic [POS_W-1:0]     quot;
   logic [SUM_W-1:0]     mag_ext;
   logic [SUM_W-1:0]     mean_ext;
   logic [SUM_W-1:0]     sum;

   assign pos_raddr = cmd.pos_hi ? k_ff : k_ff - AW'(1);

   icdf_ram #(.WIDTH(PW), .DEPTH(TABLE_ENTRIES)) u_cum_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (load_idx),
      .wdata (load_cum_prob),
      .raddr (k_ff),
      .rdata (cum_rdata)
   );

   icdf_ram #(.WIDTH(POS_W), .DEPTH(TABLE_ENTRIES)) u_pos_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (load_idx),
      .wdata (load_position),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   // cum RAM keeps reading entry k, so its output is the upper bound once the search stops
   assign v_ext    = PW'(v_ff);
   assign num_full = v_ext - y0_ff;
   assign shifted  = {rem_ff[PW-1:0], dq_ff[DW-1]};
   assign quot     = dq_ff[POS_W-1:0];
   assign mag_ext  = SUM_W'(sprod_ff[SPROD_W-1:SCALE_FRAC]);
   assign mean_ext = {{(SUM_W - POS_W){mean_offset[POS_W-1]}}, mean_offset};
   assign sum      = (neg_ff ? (~mag_ext + SUM_W'(1)) : mag_ext) + mean_ext;

   assign status.hit      = cum_rdata >= v_ext;
   assign status.k_zero   = k_ff == '0;
   assign status.k_last   = k_ff == count_limit;
   assign status.direct   = (cum_rdata <= y0_ff) || (v_ext <= y0_ff);
   assign status.div_done = div_cnt_ff == DCW'(DW - 1);

   always_comb begin
      k_in          = k_ff;
      v_in          = v_ff;
      neg_in        = neg_ff;
      y0_in         = y0_ff;
      x0_in         = x0_ff;
      dx_mag_in     = dx_mag_ff;
      dx_neg_in     = dx_neg_ff;
      den_in        = den_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      pos_in        = pos_ff;
      sprod_in      = sprod_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.start) begin
         k_in = '0;
         if (symmetric_mode) begin
            // exactly one half takes the negative side with magnitude zero
            neg_in = uniform <= HALF;
            v_in   = (uniform <= HALF) ? (HALF - uniform) : (uniform - HALF);
         end else begin
            neg_in = 1'b0;
            v_in   = uniform;
         end
      end

      if (cmd.cum_step) begin
         y0_in = cum_rdata;
         k_in  = k_ff + AW'(1);
      end

      if (cmd.x0_load) begin
         x0_in = pos_rdata;
      end

      if (cmd.dx_load) begin
         if (pos_rdata >= x0_ff) begin
            dx_mag_in = pos_rdata - x0_ff;
            dx_neg_in = 1'b0;
         end else begin
            dx_mag_in = x0_ff - pos_rdata;
            dx_neg_in = 1'b1;
         end
      end

      if (cmd.pos_direct) begin
         pos_in = x0_ff;
      end

      if (cmd.mul) begin
         dq_in      = DW'(dx_mag_ff) * DW'(num_full[PROB_BITS-1:0]);
         den_in     = cum_rdata - y0_ff;
         rem_in     = '0;
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            dq_in  = {dq_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            dq_in  = {dq_ff[DW-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + DCW'(1);
      end

      if (cmd.pos_interp) begin
         pos_in = dx_neg_ff ? (x0_ff - quot) : (x0_ff + quot);
      end

      if (cmd.scale) begin
         sprod_in = SPROD_W'(pos_ff) * SPROD_W'(std_scale);
      end

      if (cmd.fin_load) begin
         case (cmd.fin_sel)
            FIN_NOT_READY: begin
               rsp_value_in  = NEG_ONE_Q16;
               rsp_status_in = STATUS_NOT_READY;
            end
            FIN_MISS: begin
               rsp_value_in  = NEG_ONE_Q16;
               rsp_status_in = STATUS_BEYOND;
            end
            FIN_GAMMA: begin
               if (pos_ff[POS_W-1]) begin
                  rsp_value_in  = SAT_MAX;
                  rsp_status_in = STATUS_SATURATED;
               end else begin
                  rsp_value_in  = pos_ff;
                  rsp_status_in = STATUS_OK;
               end
            end
            default: begin
               // clamp when the bits above the 32-bit sign are not all sign copies
               if (!sum[SUM_W-1] && (|sum[SUM_W-2:POS_W-1])) begin
                  rsp_value_in  = SAT_MAX;
                  rsp_status_in = STATUS_SATURATED;
               end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:POS_W-1])) begin
                  rsp_value_in  = SAT_MIN;
                  rsp_status_in = STATUS_SATURATED;
               end else begin
                  rsp_value_in  = sum[POS_W-1:0];
                  rsp_status_in = STATUS_OK;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      v_ff          <= v_in;
      neg_ff        <= neg_in;
      y0_ff         <= y0_in;
      x0_ff         <= x0_in;
      dx_mag_ff     <= dx_mag_in;
      dx_neg_ff     <= dx_neg_in;
      den_ff        <= den_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      pos_ff        <= pos_in;
      sprod_ff      <= sprod_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> rtl/core/icdf_ctrl.sv
module icdf_ctrl import icdf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_type,
   input  logic            table_valid,
   input  logic            symmetric_mode,
   input  logic            rsp_stall,
   input  icdf_status_type status,
   output logic            req_stall,
   output logic            rsp_valid,
   output icdf_cmd_type    cmd
);

   state_type   state_ff, state_in;
   fin_sel_type fin_sel_ff, fin_sel_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fin_sel_ff   <= FIN_NOT_READY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_sel_ff   <= fin_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      fin_sel_in   = fin_sel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.fin_sel  = fin_sel_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && (req_type == REQ_SAMPLE)) begin
               if (!table_valid) begin
                  fin_sel_in = FIN_NOT_READY;
                  state_in   = S_FIN;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_CUM_RD;
               end
            end
         end
         S_CUM_RD: begin
            state_in = S_CUM_CHK;
         end
         S_CUM_CHK: begin
            if (!status.k_zero && status.hit) begin
               state_in = S_POS_LO;
            end else if (status.k_last) begin
               fin_sel_in = FIN_MISS;
               state_in   = S_FIN;
            end else begin
               cmd.cum_step = 1'b1;
               state_in     = S_CUM_RD;
            end
         end
         S_POS_LO: begin
            state_in = S_POS_HI;
         end
         S_POS_HI: begin
            cmd.pos_hi  = 1'b1;
            cmd.x0_load = 1'b1;
            state_in    = S_DIFF;
         end
         S_DIFF: begin
            cmd.dx_load = 1'b1;
            if (status.direct) begin
               cmd.pos_direct = 1'b1;
               if (symmetric_mode) begin
                  state_in = S_SCALE;
               end else begin
                  fin_sel_in = FIN_GAMMA;
                  state_in   = S_FIN;
               end
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_INTERP;
            end
         end
         S_INTERP: begin
            cmd.pos_interp = 1'b1;
            if (symmetric_mode) begin
               state_in = S_SCALE;
            end else begin
               fin_sel_in = FIN_GAMMA;
               state_in   = S_FIN;
            end
         end
         S_SCALE: begin
            cmd.scale  = 1'b1;
            fin_sel_in = FIN_SYM;
            state_in   = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.fin_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/inverse_cdf_table_sampler.sv
// Load beat: taken at once, no result; the next beat may follow at once.
// Sample beat: when the table is not ready, the request goes straight to the final state;
// otherwise a sequential search visits table entries, then ends in a miss, a boundary hit
// or an interpolated hit (one-bit-per-cycle divider); symmetric mode adds a scaling step.
// One sample at a time; a finished result waits in the output register.
// Synchronous reset clears control state and config registers; datapath and RAMs are not.
module inverse_cdf_table_sampler import icdf_pkg::*; #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PROB_BITS     = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] req_entry_index,
   input  logic [POS_W-1:0]                 req_entry_position,
   input  logic [PROB_BITS:0]               req_entry_cum_prob,
   input  logic [PROB_BITS-1:0]             req_uniform_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [POS_W-1:0]          rsp_sample_value,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_write,
   input  logic [CSR_IDX_W-1:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]            csr_wdata
);

   localparam int AW    = $clog2(TABLE_ENTRIES);
   localparam int LIM_W = (AW > CNT_W) ? AW : CNT_W;
   localparam logic [LIM_W-1:0] COUNT_MAX = LIM_W'(TABLE_ENTRIES - 1);

   logic               table_valid_ff, table_valid_in;
   logic               symmetric_mode_ff, symmetric_mode_in;
   logic [CNT_W-1:0]   interval_count_ff, interval_count_in;
   logic [POS_W-1:0]   mean_offset_ff, mean_offset_in;
   logic [SCALE_W-1:0] std_scale_ff, std_scale_in;

   logic               req_accept;
   logic               index_in_range;
   logic               load_we;
   logic [LIM_W-1:0]   count_ext;
   logic [LIM_W-1:0]   count_clamped;
   logic [AW-1:0]      count_limit;
   logic [POS_W-1:0]   dp_value;

   icdf_cmd_type       cmd;
   icdf_status_type    status;

   always_comb begin
      table_valid_in    = table_valid_ff;
      symmetric_mode_in = symmetric_mode_ff;
      interval_count_in = interval_count_ff;
      mean_offset_in    = mean_offset_ff;
      std_scale_in      = std_scale_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TABLE_VALID:    table_valid_in    = csr_wdata[0];
            CSR_SYMMETRIC_MODE: symmetric_mode_in = csr_wdata[0];
            CSR_INTERVAL_COUNT: interval_count_in = csr_wdata[CNT_W-1:0];
            CSR_MEAN_OFFSET:    mean_offset_in    = csr_wdata[POS_W-1:0];
            CSR_STD_SCALE:      std_scale_in      = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_valid_ff    <= 1'b0;
         symmetric_mode_ff <= 1'b0;
         interval_count_ff <= COUNT_RESET;
         mean_offset_ff    <= '0;
         std_scale_ff      <= STD_RESET;
      end else begin
         table_valid_ff    <= table_valid_in;
         symmetric_mode_ff <= symmetric_mode_in;
         interval_count_ff <= interval_count_in;
         mean_offset_ff    <= mean_offset_in;
         std_scale_ff      <= std_scale_in;
      end
   end

   assign req_accept     = req_valid && !req_stall;
   assign index_in_range = {1'b0, req_entry_index} < (AW + 1)'(TABLE_ENTRIES);
   assign load_we        = req_accept && (req_type == REQ_LOAD) && index_in_range;

   // the search never walks past the last stored entry
   assign count_ext     = LIM_W'(interval_count_ff);
   assign count_clamped = (count_ext > COUNT_MAX) ? COUNT_MAX : count_ext;
   assign count_limit   = count_clamped[AW-1:0];

   icdf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_type       (req_type),
      .table_valid    (table_valid_ff),
      .symmetric_mode (symmetric_mode_ff),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .cmd            (cmd)
   );

   icdf_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PROB_BITS     (PROB_BITS)
   ) u_datapath (
      .clock          (clock),
      .load_we        (load_we),
      .load_idx       (req_entry_index),
      .load_position  (req_entry_position),
      .load_cum_prob  (req_entry_cum_prob),
      .uniform        (req_uniform_value),
      .symmetric_mode (symmetric_mode_ff),
      .count_limit    (count_limit),
      .mean_offset    (mean_offset_ff),
      .std_scale      (std_scale_ff),
      .cmd            (cmd),
      .status         (status),
      .rsp_value      (dp_value),
      .rsp_status     (rsp_status)
   );

   assign rsp_sample_value = dp_value;

`ifndef ASSERT_OFF
   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STATUS_NOT_READY) || (rsp_status == STATUS_BEYOND))
      |-> (dp_value == NEG_ONE_Q16))
      else $error("failure status without -1.0 value");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SATURATED)
      |-> ((dp_value == SAT_MAX) || (dp_value == SAT_MIN)))
      else $error("saturated status with unclamped value");

   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat appeared without a sample in flight");
`endif

endmodule

>>> dv/icdf_draw_monitor.sv
`timescale 1ns / 1ps

module icdf_draw_monitor import icdf_pkg::*; #(
   parameter int ENTRIES   = 64,
   parameter int PROB_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_type,
   input  logic [$clog2(ENTRIES)-1:0] req_entry_index,
   input  logic [POS_W-1:0]           req_entry_position,
   input  logic [PROB_BITS:0]         req_entry_cum_prob,
   input  logic [PROB_BITS-1:0]       req_uniform_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [POS_W-1:0]    rsp_sample_value,
   input  logic [1:0]                 rsp_status,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         fail_count,
   output int                         outstanding,
   output int                         compared
);

   localparam int HALF = 1 << (PROB_BITS - 1);

   typedef struct packed {
      logic [POS_W-1:0] sample;
      logic [1:0]       status;
   } draw_result_type;

   // Local copy of the registers and of the breakpoint table
   logic                 valid_reg;
   logic                 sym_reg;
   logic [CNT_W-1:0]     count_reg;
   logic signed [31:0]   mean_reg;
   logic [SCALE_W-1:0]   std_reg;
   logic [POS_W-1:0]     pos_tab [ENTRIES];
   logic [PROB_BITS:0]   cum_tab [ENTRIES];

   draw_result_type expected_draws[$];
   int mismatches = 0;
   int matched = 0;

   task automatic report(input string msg);
      $display("[%0t] draw mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Sequential interval search with linear interpolation between breakpoints
   function automatic bit find_position(input logic [PROB_BITS:0] v, output longint pos);
      int     n;
      bit     hit;
      longint x0, x1, num, den;
      n   = count_reg;
      hit = 1'b0;
      pos = 0;
      if (n > ENTRIES - 1) n = ENTRIES - 1;
      for (int i = 0; i < n && !hit; i++) begin
         if (cum_tab[i+1] >= v) begin
            hit = 1'b1;
            x0  = pos_tab[i];
            x1  = pos_tab[i+1];
            // flat interval or value at or under its start: take the lower breakpoint
            if (cum_tab[i+1] <= cum_tab[i] || v <= cum_tab[i]) begin
               pos = x0;
            end else begin
               num = v - cum_tab[i];
               den = cum_tab[i+1] - cum_tab[i];
               pos = x0 + ((x1 - x0) * num) / den;
            end
         end
      end
      return hit;
   endfunction

   function automatic draw_result_type predict_draw(input logic [PROB_BITS-1:0] u);
      draw_result_type    r;
      longint             pos, prod, scaled, mean, sc, res;
      bit                 neg;
      logic [PROB_BITS:0] mag;
      if (!valid_reg) begin
         r.sample = NEG_ONE_Q16;
         r.status = STATUS_NOT_READY;
         return r;
      end
      if (!sym_reg) begin
         if (!find_position({1'b0, u}, pos)) begin
            r.sample = NEG_ONE_Q16;
            r.status = STATUS_BEYOND;
            return r;
         end
         res = pos;
      end else begin
         // exactly one half falls on the negative side with magnitude zero
         neg = (u <= HALF);
         mag = neg ? (HALF - u) : (u - HALF);
         if (!find_position(mag, pos)) begin
            r.sample = NEG_ONE_Q16;
            r.status = STATUS_BEYOND;
            return r;
         end
         if (pos < 0) begin
            neg = !neg;
            pos = -pos;
         end
         sc     = std_reg;
         prod   = (pos * sc) >>> SCALE_FRAC;
         scaled = neg ? -prod : prod;
         mean   = mean_reg;
         res    = scaled + mean;
      end
      if (res > 64'sd2147483647) begin
         r.sample = SAT_MAX;
         r.status = STATUS_SATURATED;
      end else if (res < -64'sd2147483648) begin
         r.sample = SAT_MIN;
         r.status = STATUS_SATURATED;
      end else begin
         r.sample = res[POS_W-1:0];
         r.status = STATUS_OK;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      draw_result_type want;
      if (reset) begin
         valid_reg = 1'b0;
         sym_reg   = 1'b0;
         count_reg = COUNT_RESET;
         mean_reg  = '0;
         std_reg   = STD_RESET;
         expected_draws.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TABLE_VALID:    valid_reg = csr_wdata[0];
               CSR_SYMMETRIC_MODE: sym_reg   = csr_wdata[0];
               CSR_INTERVAL_COUNT: count_reg = csr_wdata[CNT_W-1:0];
               CSR_MEAN_OFFSET:    mean_reg  = csr_wdata;
               CSR_STD_SCALE:      std_reg   = csr_wdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         // compare before taking a new beat: a result never belongs to the
         // draw accepted on the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_draws.size() == 0) begin
               report($sformatf("unexpected result value %h status %0d",
                                rsp_sample_value, rsp_status));
            end else begin
               want = expected_draws.pop_front();
               matched++;
               if (rsp_sample_value !== want.sample)
                  report($sformatf("sample_value %h, expected %h",
                                   rsp_sample_value, want.sample));
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, expected %0d", rsp_status, want.status));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == REQ_LOAD) begin
               pos_tab[req_entry_index] = req_entry_position;
               cum_tab[req_entry_index] = req_entry_cum_prob;
            end else begin
               expected_draws.push_back(predict_draw(req_uniform_value));
            end
         end
      end
      outstanding <= expected_draws.size();
      fail_count  <= mismatches;
      compared    <= matched;
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import icdf_pkg::*;

   localparam int ENTRIES         = 64;
   localparam int PROB_BITS       = 16;
   localparam int ONE_Q16         = 65536;
   localparam int HALF_Q16        = 32768;
   localparam int NUM_PHASES      = 18;
   localparam int DRAWS_PER_PHASE = 60;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 300;
   localparam int LIMIT           = 3_000_000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_type;
   logic [5:0]            req_entry_index;
   logic [POS_W-1:0]      req_entry_position;
   logic [PROB_BITS:0]    req_entry_cum_prob;
   logic [PROB_BITS-1:0]  req_uniform_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [POS_W-1:0] rsp_sample_value;
   logic [1:0]            rsp_status;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int outstanding;
   int compared;
   int cycle_count;

   int loads_sent    = 0;
   int draws_sent    = 0;
   int settings_made = 0;
   bit no_gaps       = 1'b0;

   // what the table holds now, used only to aim draws at breakpoints
   logic [PROB_BITS:0] cum_now [ENTRIES];

   inverse_cdf_table_sampler #(
      .TABLE_ENTRIES(ENTRIES),
      .PROB_BITS(PROB_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_entry_index(req_entry_index),
      .req_entry_position(req_entry_position),
      .req_entry_cum_prob(req_entry_cum_prob),
      .req_uniform_value(req_uniform_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_value(rsp_sample_value),
      .rsp_status(rsp_status),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   icdf_draw_monitor #(
      .ENTRIES(ENTRIES),
      .PROB_BITS(PROB_BITS)
   ) u_draw_monitor (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_entry_index(req_entry_index),
      .req_entry_position(req_entry_position),
      .req_entry_cum_prob(req_entry_cum_prob),
      .req_uniform_value(req_uniform_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_value(rsp_sample_value),
      .rsp_status(rsp_status),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .outstanding(outstanding),
      .compared(compared)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("inverse_cdf_table_sampler verification failed");
      $finish;
   end

   // Result side back-pressure: mostly short bursts, a few long holds
   initial begin
      int r, n;
      rsp_stall <= 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 4);
         end else if (r < 60) begin
            rsp_stall <= 1'b0;
            n = $urandom_range(50, 300);
         end else if (r < 95) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 4);
         end else begin
            rsp_stall <= 1'b1;
            n = $urandom_range(20, 60);
         end
         repeat (n) @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Hold the beat until it is taken; keep valid high for a back-to-back beat
   task automatic send_beat(input logic kind, input logic [5:0] idx,
                            input logic [POS_W-1:0] pos, input logic [PROB_BITS:0] cum,
                            input logic [PROB_BITS-1:0] u);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_entry_index    <= idx;
      req_entry_position <= pos;
      req_entry_cum_prob <= cum;
      req_uniform_value  <= u;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_entry(input int idx, input logic [POS_W-1:0] pos, input int cum);
      send_beat(REQ_LOAD, 6'(idx), pos, 17'(cum), 16'($urandom));
      cum_now[idx] = 17'(cum);
      loads_sent++;
   endtask

   task automatic draw(input int u);
      send_beat(REQ_SAMPLE, 6'($urandom), $urandom, 17'($urandom_range(0, ONE_Q16)), 16'(u));
      draws_sent++;
   endtask

   // Drop valid, let every result come back, then wait out any load in flight
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pad_above(input int w, input logic [31:0] v);
      if ($urandom_range(0, 3) != 0) return v;
      return v | (($urandom >> w) << w);
   endfunction

   task automatic set_regs(input logic valid, input logic sym, input logic [CNT_W-1:0] count,
                           input logic [31:0] mean, input logic [SCALE_W-1:0] std);
      csr_write <= 1'b1;
      csr_index <= CSR_TABLE_VALID;
      csr_wdata <= pad_above(1, {31'b0, valid});
      @(posedge clock);
      csr_index <= CSR_SYMMETRIC_MODE;
      csr_wdata <= pad_above(1, {31'b0, sym});
      @(posedge clock);
      csr_index <= CSR_INTERVAL_COUNT;
      csr_wdata <= pad_above(CNT_W, {26'b0, count});
      @(posedge clock);
      csr_index <= CSR_MEAN_OFFSET;
      csr_wdata <= mean;
      @(posedge clock);
      csr_index <= CSR_STD_SCALE;
      csr_wdata <= pad_above(SCALE_W, {8'b0, std});
      @(posedge clock);
      if ($urandom_range(0, 1) == 0) begin
         csr_index <= 3'($urandom_range(CSR_UNMAPPED_LO, CSR_UNMAPPED_HI));
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_write <= 1'b0;
      settings_made++;
   endtask

   // Monotonic cumulative curve with flat steps; positions mostly rising
   task automatic build_ramp(input int count, input int top_p, input int start_p);
      logic [POS_W-1:0] p;
      int  c, prev, remain, shift;
      bit  allow_down;
      shift      = $urandom_range(0, 24);
      p          = $urandom >> $urandom_range(shift, 31);
      allow_down = ($urandom_range(0, 3) == 0);
      prev       = start_p;
      for (int i = 0; i <= count; i++) begin
         if (i == 0) begin
            c = start_p;
         end else if (i == count) begin
            c = top_p;
         end else begin
            remain = top_p - prev;
            if ($urandom_range(0, 6) == 0) c = prev;
            else c = prev + $urandom_range(0, 2 * remain / (count - i + 1));
            if (c > top_p) c = top_p;
         end
         load_entry(i, p, c);
         prev = c;
         if (allow_down && $urandom_range(0, 2) == 0) p = p - ($urandom >> shift);
         else p = p + ($urandom >> shift);
      end
   endtask

   task automatic build_noise(input int count);
      for (int i = 0; i <= count; i++) load_entry(i, $urandom, $urandom_range(0, ONE_Q16));
   endtask

   // Aim at breakpoints (and one step either side), the extremes, or anywhere
   function automatic int pick_uniform(input int count, input bit sym);
      int r, c, u;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         c = int'(cum_now[$urandom_range(0, count)]) + int'($urandom_range(0, 2)) - 1;
         if (sym) u = ($urandom_range(0, 1) == 1) ? HALF_Q16 - c : HALF_Q16 + c;
         else u = c;
      end else if (r < 40) begin
         case ($urandom_range(0, 4))
            0:       u = 0;
            1:       u = ONE_Q16 - 1;
            2:       u = HALF_Q16;
            3:       u = HALF_Q16 - 1;
            default: u = HALF_Q16 + 1;
         endcase
      end else begin
         u = $urandom_range(0, ONE_Q16 - 1);
      end
      if (u < 0) u = 0;
      if (u > ONE_Q16 - 1) u = ONE_Q16 - 1;
      return u;
   endfunction

   initial begin
      int          count, r, top_p, start_p;
      logic        valid_sel, sym_sel;
      logic [31:0] mean_sel;
      logic [23:0] std_sel;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_type           <= REQ_LOAD;
      req_entry_index    <= '0;
      req_entry_position <= '0;
      req_entry_cum_prob <= '0;
      req_uniform_value  <= '0;
      csr_write          <= 1'b0;
      csr_index          <= CSR_TABLE_VALID;
      csr_wdata          <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // table not ready out of reset
      draw(0);
      draw(ONE_Q16 - 1);

      // fill every entry so no search ever meets an unwritten one
      for (int i = 0; i < ENTRIES; i++) load_entry(i, $urandom, $urandom_range(0, ONE_Q16));

      // gamma: flat interval, boundary hits, saturation, descending step
      settle();
      set_regs(1'b1, 1'b0, 6'd4, 32'h0, STD_RESET);
      load_entry(0, 32'h0000_0000, 0);
      load_entry(1, 32'h0001_0000, 16384);
      load_entry(2, 32'h0003_0000, 16384);
      load_entry(3, 32'hFFFF_FFFF, 49152);
      load_entry(4, 32'h0000_8000, ONE_Q16);
      draw(0);
      draw(16384);
      draw(16385);
      draw(30000);
      draw(49152);
      draw(60000);
      draw(ONE_Q16 - 1);

      // single interval: beyond the last breakpoint, value under the first
      settle();
      set_regs(1'b1, 1'b0, 6'd1, 32'h0, STD_RESET);
      draw(ONE_Q16 - 1);
      load_entry(0, 32'h0002_0000, 1000);
      draw(500);

      // symmetric: exact half, magnitude extremes, largest and most negative offset, largest and zero scale
      settle();
      set_regs(1'b1, 1'b1, 6'd4, 32'h7FFF_FFFF, 24'hFF_FFFF);
      draw(HALF_Q16);
      draw(0);
      draw(ONE_Q16 - 1);
      settle();
      set_regs(1'b1, 1'b1, 6'd63, 32'h8000_0000, 24'h0);
      draw(0);
      draw(40000);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         valid_sel = ($urandom_range(0, 9) != 0);
         sym_sel   = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 99);
         if (r < 15) count = 1;
         else if (r < 30) count = 63;
         else if (r < 85) count = $urandom_range(2, 12);
         else count = $urandom_range(13, 62);
         r = $urandom_range(0, 99);
         if (r < 15) mean_sel = 32'h8000_0000;
         else if (r < 30) mean_sel = 32'h7FFF_FFFF;
         else if (r < 50) mean_sel = 32'h0;
         else if (r < 75) mean_sel = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         else mean_sel = $urandom;
         r = $urandom_range(0, 99);
         if (r < 10) std_sel = 24'h0;
         else if (r < 20) std_sel = 24'hFF_FFFF;
         else if (r < 40) std_sel = STD_RESET;
         else if (r < 70) std_sel = 24'($urandom_range(0, 4 * ONE_Q16));
         else std_sel = 24'($urandom);
         set_regs(valid_sel, sym_sel, 6'(count), mean_sel, std_sel);

         no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 7) begin
            top_p = sym_sel ? HALF_Q16 : ONE_Q16;
            if ($urandom_range(0, 6) == 0) top_p = $urandom_range(top_p / 2, top_p - 1);
            start_p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, top_p / 4) : 0;
            build_ramp(count, top_p, start_p);
         end else begin
            build_noise(count);
         end

         for (int k = 0; k < DRAWS_PER_PHASE; k++) begin
            // rewrite an entry between draws now and then
            if ($urandom_range(0, 99) < 6)
               load_entry($urandom_range(0, ENTRIES - 1), $urandom, $urandom_range(0, ONE_Q16));
            draw(pick_uniform(count, sym_sel));
         end
      end

      no_gaps = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d table loads and %0d draws across %0d register settings",
               loads_sent, draws_sent, settings_made);
      $display("%0d results compared in %0d cycles, %0d mismatches",
               compared, cycle_count, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("inverse_cdf_table_sampler verification clean");
      end else begin
         $display("inverse_cdf_table_sampler verification failed");
      end
      $finish;
   end

endmodule
